// ----- sv/lf_pkg.sv -----
package lf_pkg;

    localparam int LIGHT_BITS = 16;

    localparam int THR_W  = 16;
    localparam int CMP_W  = (LIGHT_BITS > THR_W) ? LIGHT_BITS : THR_W;
    localparam int POT_W  = 8;
    localparam int TICK_W = 8;
    localparam int CNT_W  = 16;
    localparam int LVL_W  = 8;
    localparam int MIN_W  = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int S_FIELDS_W = LIGHT_BITS + POT_W + TICK_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = LVL_W + LVL_W + 2 + 1;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DARK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TPS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MINRS  = 2'd3;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_DAWN = 2'd1,
        MODE_ON   = 2'd2,
        MODE_DUSK = 2'd3
    } t_mode;

    typedef struct packed {
        logic [THR_W-1:0] dark_threshold;
        logic [THR_W-1:0] bright_threshold;
        logic [CNT_W-1:0] ticks_per_step;
        logic [MIN_W-1:0] min_ramp_start;
    } t_cfg;

    typedef struct packed {
        logic             pulse_enable;
        t_mode            fade_mode;
        logic [LVL_W-1:0] brightness;
        logic [LVL_W-1:0] duty_compare;
    } t_result;

endpackage

// ----- sv/lf_cfg.sv -----
module lf_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [lf_pkg::CFG_IDX_W-1:0]   i_idx,
    input  logic [lf_pkg::CFG_DATA_W-1:0]  i_wdata,
    output lf_pkg::t_cfg                   o_cfg
);

    lf_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dark_threshold   <= lf_pkg::THR_W'(150);
            r_cfg.bright_threshold <= lf_pkg::THR_W'(200);
            r_cfg.ticks_per_step   <= lf_pkg::CNT_W'(300);
            r_cfg.min_ramp_start   <= lf_pkg::MIN_W'(5);
        end else if (i_we) begin
            unique case (i_idx)
                lf_pkg::CFG_DARK:   r_cfg.dark_threshold   <= i_wdata[lf_pkg::THR_W-1:0];
                lf_pkg::CFG_BRIGHT: r_cfg.bright_threshold <= i_wdata[lf_pkg::THR_W-1:0];
                lf_pkg::CFG_TPS:    r_cfg.ticks_per_step   <= i_wdata[lf_pkg::CNT_W-1:0];
                lf_pkg::CFG_MINRS:  r_cfg.min_ramp_start   <= i_wdata[lf_pkg::MIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/lf_core.sv -----
module lf_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  lf_pkg::t_cfg                    i_cfg,
    input  logic [lf_pkg::LIGHT_BITS-1:0]   i_light,
    input  logic [lf_pkg::POT_W-1:0]        i_pot,
    input  logic [lf_pkg::TICK_W-1:0]       i_ticks,
    output lf_pkg::t_result                 o_result
);

    localparam int LB = lf_pkg::LIGHT_BITS;

    logic [LB-1:0]                r_la, n_la;
    logic [lf_pkg::POT_W-1:0]     r_pa, n_pa;
    logic [lf_pkg::LVL_W-1:0]     r_lvl, n_lvl;
    lf_pkg::t_mode                r_mode, n_mode;
    logic [lf_pkg::CNT_W-1:0]     r_sec, n_sec;
    logic [lf_pkg::CNT_W-1:0]     r_tick, n_tick;

    logic [LB+5:0]                la_acc;
    logic [lf_pkg::POT_W+3:0]     pa_acc;
    logic [lf_pkg::CNT_W:0]       tick_sum;
    logic [lf_pkg::CNT_W-1:0]     tick_sat;
    logic [lf_pkg::LVL_W-1:0]     dusk_diff;
    logic [lf_pkg::CNT_W-1:0]     pa_ext;
    logic [lf_pkg::CNT_W-1:0]     min_ext;
    logic                         go_dawn;
    logic                         go_dusk;

    always_comb begin
        // average*31 + sample, no wrap before the shift
        la_acc = {1'b0, r_la, 5'b0} - {6'b0, r_la} + {6'b0, i_light};
        n_la   = la_acc[LB+4:5];
        pa_acc = {r_pa, 4'b0} - {4'b0, r_pa} + {4'b0, ~i_pot};
        n_pa   = pa_acc[lf_pkg::POT_W+3:4];

        pa_ext  = {{(lf_pkg::CNT_W-lf_pkg::POT_W){1'b0}}, n_pa};
        min_ext = {{(lf_pkg::CNT_W-lf_pkg::MIN_W){1'b0}}, i_cfg.min_ramp_start};

        tick_sum = {1'b0, r_tick} + {{(lf_pkg::CNT_W+1-lf_pkg::TICK_W){1'b0}}, i_ticks};
        tick_sat = tick_sum[lf_pkg::CNT_W] ? {lf_pkg::CNT_W{1'b1}}
                                           : tick_sum[lf_pkg::CNT_W-1:0];
        n_tick = tick_sat;
        n_sec  = r_sec;
        n_mode = r_mode;
        n_lvl  = r_lvl;
        if (tick_sat > i_cfg.ticks_per_step) begin
            n_tick = '0;
            n_sec  = r_sec + 1'b1;
        end

        go_dawn = (lf_pkg::CMP_W'(n_la) < lf_pkg::CMP_W'(i_cfg.dark_threshold)) &&
                  (r_mode == lf_pkg::MODE_OFF || r_mode == lf_pkg::MODE_DUSK);
        if (go_dawn) begin
            n_tick = '0;
            n_sec  = ({{(lf_pkg::CNT_W-lf_pkg::LVL_W){1'b0}}, r_lvl} < min_ext) ? '0
                     : {{(lf_pkg::CNT_W-lf_pkg::LVL_W){1'b0}}, r_lvl};
            n_mode = lf_pkg::MODE_DAWN;
        end

        dusk_diff = (n_pa > r_lvl) ? (n_pa - r_lvl) : '0;
        go_dusk = (lf_pkg::CMP_W'(n_la) > lf_pkg::CMP_W'(i_cfg.bright_threshold)) &&
                  (n_mode == lf_pkg::MODE_ON || n_mode == lf_pkg::MODE_DAWN);
        if (go_dusk) begin
            n_tick = '0;
            n_sec  = ({{(lf_pkg::CNT_W-lf_pkg::LVL_W){1'b0}}, dusk_diff} < min_ext) ? '0
                     : {{(lf_pkg::CNT_W-lf_pkg::LVL_W){1'b0}}, dusk_diff};
            n_mode = lf_pkg::MODE_DUSK;
        end

        unique case (n_mode)
            lf_pkg::MODE_OFF: n_lvl = '0;
            lf_pkg::MODE_DAWN: begin
                if (n_sec < pa_ext) n_lvl = n_sec[lf_pkg::LVL_W-1:0];
                else                n_mode = lf_pkg::MODE_ON;
            end
            lf_pkg::MODE_ON: n_lvl = n_pa;
            lf_pkg::MODE_DUSK: begin
                if (n_sec < pa_ext) n_lvl = n_pa - n_sec[lf_pkg::LVL_W-1:0];
                else                n_mode = lf_pkg::MODE_OFF;
            end
            default: n_lvl = r_lvl;
        endcase

        o_result.duty_compare = ~n_lvl;
        o_result.brightness   = n_lvl;
        o_result.fade_mode    = n_mode;
        o_result.pulse_enable = (n_mode != lf_pkg::MODE_OFF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_la   <= '0;
            r_pa   <= '0;
            r_lvl  <= '0;
            r_mode <= lf_pkg::MODE_OFF;
            r_sec  <= '0;
            r_tick <= '0;
        end else if (i_step) begin
            r_la   <= n_la;
            r_pa   <= n_pa;
            r_lvl  <= n_lvl;
            r_mode <= n_mode;
            r_sec  <= n_sec;
            r_tick <= n_tick;
        end
    end

endmodule

// ----- sv/light_triggered_led_fader.sv -----
// Channel   | Direction | Payload
// s_axis    | in        | tdata: light_sample, pot_sample, elapsed_ticks
// m_axis    | out       | tdata: duty_compare, brightness, fade_mode, pulse_enable
// cfg       | in        | i_cfg_we / i_cfg_idx / i_cfg_wdata, no read-back
//
// One request per cycle when m_axis_tready is high; through input and result registers.
// The control step is one pass of logic from the input register into state and result.
// Synchronous active-low reset clears state and both valid flags and loads config defaults.
// A stalled result holds; the input register takes a request while a result waits if empty.
module light_triggered_led_fader (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [LIGHT_BITS-1:0] light_sample, then pot_sample, elapsed_ticks
    input  logic [lf_pkg::S_DATA_W-1:0]      s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] duty_compare, [15:8] brightness, [17:16] fade_mode, [18] pulse_enable
    output logic [lf_pkg::M_DATA_W-1:0]      m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [lf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lf_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int LB = lf_pkg::LIGHT_BITS;

    lf_pkg::t_cfg                    cfg;
    lf_pkg::t_result                 result;
    logic                            r_in_valid;
    logic [lf_pkg::S_FIELDS_W-1:0]   r_in_data;
    logic                            r_out_valid;
    lf_pkg::t_result                 r_out;
    logic                            adv;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            if (adv) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) r_in_data <= s_axis_tdata[lf_pkg::S_FIELDS_W-1:0];
        if (adv) r_out <= result;
    end

    lf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    lf_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv),
        .i_cfg    (cfg),
        .i_light  (r_in_data[LB-1:0]),
        .i_pot    (r_in_data[LB+lf_pkg::POT_W-1:LB]),
        .i_ticks  (r_in_data[lf_pkg::S_FIELDS_W-1:LB+lf_pkg::POT_W]),
        .o_result (result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = lf_pkg::M_DATA_W'(r_out);

endmodule

// ----- sv/lf_checker.sv -----
module lf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [lf_pkg::M_DATA_W-1:0]      m_axis_tdata
);

    a_duty_inverse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] == ~m_axis_tdata[15:8]))
        else $error("duty_compare is not 255 - brightness");

    a_enable_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[18] == (m_axis_tdata[17:16] != lf_pkg::MODE_OFF)))
        else $error("pulse_enable disagrees with fade_mode");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind light_triggered_led_fader lf_checker u_lf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
